// ===== hdl/rpr_pkg.sv =====
// Shared types and constants for the random page replacement block.
`default_nettype none
package rpr_pkg;

    localparam int          CFG_INDEX_W     = 2;
    localparam int          CFG_DATA_W      = 16;
    localparam int          LFSR_W          = 16;
    localparam int          PAGE_IN_W       = 7;
    localparam int          LIMIT_W         = 8;
    localparam int          COUNT_W         = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANDOM_SEED = 2'd1;

    localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;
    localparam logic [LFSR_W-1:0]  SEED_RESET  = 16'd44257;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_DRAW,
        S_PLACE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_draw_ctl;

endpackage
`default_nettype wire

// ===== hdl/rpr_present_mem.sv =====
// Present-bit memory: one write port, one registered read port.
`default_nettype none
module rpr_present_mem #(
    parameter int PAGE_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [PAGE_W-1:0] i_waddr,
    input  wire logic              i_wdata,
    input  wire logic [PAGE_W-1:0] i_raddr,
    output logic                   o_rdata
);

    logic r_mem [2**PAGE_W];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/rpr_draw_unit.sv =====
// Galois LFSR draw unit: one candidate page per step.
`default_nettype none
module rpr_draw_unit
    import rpr_pkg::*;
#(
    parameter int PAGE_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_draw_ctl         i_ctl,
    input  wire logic [LFSR_W-1:0] i_seed,
    output logic [PAGE_W-1:0]      o_cand
);

    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] n_lfsr;
    logic [LFSR_W-1:0] w_step;
    logic [LFSR_W-1:0] w_seed;

    assign w_step = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign w_seed = (i_seed == '0) ? LFSR_W'(1) : i_seed;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_ctl.load) begin
            n_lfsr = w_seed;
        end else if (i_ctl.step) begin
            n_lfsr = w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    // candidate comes from the advanced state
    assign o_cand = w_step[PAGE_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/random_page_replacement.sv =====
// Top level: random page replacement with sequencer, counters and config.
//
// channel   | handshake                   | payload
// request   | start, busy                 | i_page, i_restart
// result    | o_valid (one-cycle strobe)  | o_hit, o_evicted, o_victim_page, o_hit_total,
//           |                             | o_reference_total
// config    | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Hit or free-frame fill: present-bit read, then decision in S_CHECK. Eviction: S_CHECK,
// then S_DRAW repeated per LFSR draw, each candidate read through the single present-bit read
// port, then S_PLACE. A restart request adds a clearing sweep (S_CLEAR) and S_LOOKUP. After
// reset the block sweeps the present-bit memory with busy high; config is taken always.
// Results cannot be stalled; o_valid pulses once per request.
`default_nettype none
module random_page_replacement
    import rpr_pkg::*;
#(
    parameter int PAGE_COUNT = 128
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [PAGE_IN_W-1:0]   i_page,
    input  wire logic                   i_restart,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic                        o_evicted,
    output logic [PAGE_IN_W-1:0]        o_victim_page,
    output logic [COUNT_W-1:0]          o_hit_total,
    output logic [COUNT_W-1:0]          o_reference_total,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);

    t_state                r_state, n_state;
    logic [LIMIT_W-1:0]    r_limit;
    logic [LFSR_W-1:0]     r_seed;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic [PAGE_W-1:0]     r_cand, n_cand;
    logic [PAGE_W-1:0]     r_clr_addr, n_clr_addr;
    logic                  r_after_clear, n_after_clear;
    logic [LIMIT_W-1:0]    r_alloc, n_alloc;
    logic [COUNT_W-1:0]    r_hit_cnt, n_hit_cnt;
    logic [COUNT_W-1:0]    r_ref_cnt, n_ref_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_evicted, n_out_evicted;
    logic [PAGE_IN_W-1:0]  r_out_victim, n_out_victim;
    logic [COUNT_W-1:0]    r_out_hit_total, n_out_hit_total;
    logic [COUNT_W-1:0]    r_out_ref_total, n_out_ref_total;

    logic                  w_we;
    logic [PAGE_W-1:0]     w_waddr;
    logic                  w_wdata;
    logic [PAGE_W-1:0]     w_raddr;
    logic                  w_present;
    logic [PAGE_W-1:0]     w_cand;
    t_draw_ctl             w_draw_ctl;
    logic [PAGE_W-1:0]     w_in_page;
    logic [PAGE_W+PAGE_IN_W-1:0] w_page_ext;
    logic [PAGE_W+PAGE_IN_W-1:0] w_victim_ext;
    logic [LIMIT_W-1:0]    w_limit;
    logic [COUNT_W-1:0]    w_ref_inc;
    logic [COUNT_W-1:0]    w_hit_inc;

    assign w_page_ext   = {{PAGE_W{1'b0}}, i_page};
    assign w_in_page    = w_page_ext[PAGE_W-1:0];
    assign w_victim_ext = {{PAGE_IN_W{1'b0}}, r_cand};
    assign w_limit      = (r_limit == '0) ? LIMIT_W'(1) : r_limit;
    assign w_ref_inc    = (r_ref_cnt == COUNT_MAX) ? r_ref_cnt : r_ref_cnt + 1'b1;
    assign w_hit_inc    = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;

    rpr_present_mem #(
        .PAGE_W (PAGE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_present)
    );

    rpr_draw_unit #(
        .PAGE_W (PAGE_W)
    ) u_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_draw_ctl),
        .i_seed  (r_seed),
        .o_cand  (w_cand)
    );

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_seed  <= SEED_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_RANDOM_SEED: r_seed  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state         = r_state;
        n_page          = r_page;
        n_cand          = r_cand;
        n_clr_addr      = r_clr_addr;
        n_after_clear   = r_after_clear;
        n_alloc         = r_alloc;
        n_hit_cnt       = r_hit_cnt;
        n_ref_cnt       = r_ref_cnt;
        n_out_valid     = 1'b0;
        n_out_hit       = r_out_hit;
        n_out_evicted   = r_out_evicted;
        n_out_victim    = r_out_victim;
        n_out_hit_total = r_out_hit_total;
        n_out_ref_total = r_out_ref_total;
        w_we            = 1'b0;
        w_waddr         = r_page;
        w_wdata         = 1'b0;
        w_raddr         = r_page;
        w_draw_ctl      = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state       = r_after_clear ? S_LOOKUP : S_IDLE;
                    n_after_clear = 1'b0;
                end
            end
            S_IDLE: begin
                w_raddr = w_in_page;
                if (start) begin
                    n_page = w_in_page;
                    if (i_restart) begin
                        n_alloc         = '0;
                        n_hit_cnt       = '0;
                        n_ref_cnt       = '0;
                        w_draw_ctl.load = 1'b1;
                        n_clr_addr      = '0;
                        n_after_clear   = 1'b1;
                        n_state         = S_CLEAR;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_LOOKUP: begin
                w_raddr = r_page;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_ref_cnt       = w_ref_inc;
                n_out_ref_total = w_ref_inc;
                n_out_hit       = 1'b0;
                n_out_evicted   = 1'b0;
                n_out_victim    = '0;
                n_out_hit_total = r_hit_cnt;
                if (w_present) begin
                    n_hit_cnt       = w_hit_inc;
                    n_out_hit       = 1'b1;
                    n_out_hit_total = w_hit_inc;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_alloc < w_limit) begin
                    n_alloc     = r_alloc + 1'b1;
                    w_we        = 1'b1;
                    w_waddr     = r_page;
                    w_wdata     = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    w_draw_ctl.step = 1'b1;
                    w_raddr         = w_cand;
                    n_cand          = w_cand;
                    n_state         = S_DRAW;
                end
            end
            S_DRAW: begin
                if (w_present) begin
                    w_we    = 1'b1;
                    w_waddr = r_cand;
                    w_wdata = 1'b0;
                    n_state = S_PLACE;
                end else begin
                    w_draw_ctl.step = 1'b1;
                    w_raddr         = w_cand;
                    n_cand          = w_cand;
                end
            end
            S_PLACE: begin
                w_we          = 1'b1;
                w_waddr       = r_page;
                w_wdata       = 1'b1;
                n_out_evicted = 1'b1;
                n_out_victim  = w_victim_ext[PAGE_IN_W-1:0];
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_after_clear <= 1'b0;
            r_alloc       <= '0;
            r_hit_cnt     <= '0;
            r_ref_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_after_clear <= n_after_clear;
            r_alloc       <= n_alloc;
            r_hit_cnt     <= n_hit_cnt;
            r_ref_cnt     <= n_ref_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page          <= n_page;
        r_cand          <= n_cand;
        r_out_hit       <= n_out_hit;
        r_out_evicted   <= n_out_evicted;
        r_out_victim    <= n_out_victim;
        r_out_hit_total <= n_out_hit_total;
        r_out_ref_total <= n_out_ref_total;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_evicted         = r_out_evicted;
    assign o_victim_page     = r_out_victim;
    assign o_hit_total       = r_out_hit_total;
    assign o_reference_total = r_out_ref_total;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for random_page_replacement: directed and random reference streams.
module tb_top;
    import rpr_pkg::*;

    localparam int PAGES = 128;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PAGE_IN_W-1:0] page;
        logic                 restart;
    } t_page_request;

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [PAGE_IN_W-1:0] victim;
        logic [COUNT_W-1:0]   hit_total;
        logic [COUNT_W-1:0]   ref_total;
    } t_page_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PAGE_IN_W-1:0]   i_page = '0;
    logic                   i_restart = 1'b0;
    logic                   o_valid;
    logic                   o_hit;
    logic                   o_evicted;
    logic [PAGE_IN_W-1:0]   o_victim_page;
    logic [COUNT_W-1:0]     o_hit_total;
    logic [COUNT_W-1:0]     o_reference_total;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_page_request pending_references[$];
    t_page_result  expected_outcomes[$];
    int            refs_queued = 0;
    int            outcomes_seen = 0;
    int            mismatch_count = 0;
    int            idle_pct = 0;

    // shadow of the block state
    logic [LIMIT_W-1:0] limit_shadow;
    logic [LFSR_W-1:0]  seed_shadow;
    bit                 page_present[PAGES];
    logic [LIMIT_W-1:0] frames_used;
    logic [LFSR_W-1:0]  lfsr_shadow;
    logic [COUNT_W-1:0] hits_shadow;
    logic [COUNT_W-1:0] refs_shadow;

    random_page_replacement #(
        .PAGE_COUNT(PAGES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_page           (i_page),
        .i_restart        (i_restart),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_victim_page    (o_victim_page),
        .o_hit_total      (o_hit_total),
        .o_reference_total(o_reference_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_table();
        page_present = '{default: 1'b0};
        frames_used  = '0;
        hits_shadow  = '0;
        refs_shadow  = '0;
        lfsr_shadow  = (seed_shadow == '0) ? LFSR_W'(1) : seed_shadow;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void predict_reference(input logic [PAGE_IN_W-1:0] pg, input logic rs);
        t_page_result       r;
        logic [LIMIT_W-1:0] lim;
        logic [PAGE_IN_W-1:0] cand;
        int unsigned        draw;
        r   = '0;
        lim = (limit_shadow == '0) ? LIMIT_W'(1) : limit_shadow;
        if (rs) clear_table();
        refs_shadow = sat_inc(refs_shadow);
        if (page_present[pg]) begin
            r.hit = 1'b1;
            hits_shadow = sat_inc(hits_shadow);
        end else if (frames_used < lim) begin
            frames_used = frames_used + 1'b1;
            page_present[pg] = 1'b1;
        end else begin
            for (draw = 0; draw < 65536 && !r.evicted; draw++) begin
                lfsr_shadow = {1'b0, lfsr_shadow[LFSR_W-1:1]} ^ (lfsr_shadow[0] ? LFSR_TAPS : '0);
                cand = lfsr_shadow[PAGE_IN_W-1:0];
                if (page_present[cand]) begin
                    r.evicted = 1'b1;
                    r.victim  = cand;
                end
            end
            if (r.evicted) begin
                page_present[r.victim] = 1'b0;
                page_present[pg] = 1'b1;
            end
        end
        r.hit_total = hits_shadow;
        r.ref_total = refs_shadow;
        expected_outcomes.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 200)
            $display("[%0t] reference %0d: %s", $time, outcomes_seen, what);
        mismatch_count++;
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        logic          next_start;
        t_page_request req;
        int            gap_left;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                predict_reference(i_page, i_restart);
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_references.size() != 0) begin
                    req = pending_references.pop_front();
                    i_page     <= req.page;
                    i_restart  <= req.restart;
                    next_start = 1'b1;
                    if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                        gap_left = $urandom_range(1, 12);
                end
            end
            start <= next_start;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_page_result want;
        if (i_rst_n && o_valid) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result with no reference pending");
            end else begin
                want = expected_outcomes.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", o_hit, want.hit));
                if (o_evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, want %b", o_evicted, want.evicted));
                if (o_victim_page !== want.victim)
                    report_mismatch($sformatf("victim_page %0d, want %0d",
                                              o_victim_page, want.victim));
                if (o_hit_total !== want.hit_total)
                    report_mismatch($sformatf("hit_total %0d, want %0d",
                                              o_hit_total, want.hit_total));
                if (o_reference_total !== want.ref_total)
                    report_mismatch($sformatf("reference_total %0d, want %0d",
                                              o_reference_total, want.ref_total));
            end
            outcomes_seen++;
        end
    end

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_LIMIT: limit_shadow = data[LIMIT_W-1:0];
            CFG_RANDOM_SEED: seed_shadow = data;
            default: ;
        endcase
    endtask

    task automatic queue_reference(input int pg, input bit rs);
        t_page_request req;
        req.page    = pg[PAGE_IN_W-1:0];
        req.restart = rs;
        pending_references.push_back(req);
        refs_queued++;
    endtask

    task automatic wait_idle();
        while (outcomes_seen < refs_queued) @(posedge i_clk);
    endtask

    task automatic queue_random_phase(input int count);
        int ws_base;
        int ws_size;
        int local_pct;
        int pg;
        ws_base   = $urandom_range(0, PAGES - 1);
        ws_size   = $urandom_range(1, 48);
        local_pct = $urandom_range(50, 95);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < local_pct)
                pg = (ws_base + $urandom_range(0, ws_size - 1)) % PAGES;
            else
                pg = $urandom_range(0, PAGES - 1);
            if (k == 0)
                queue_reference(pg, $urandom_range(3) != 0);
            else
                queue_reference(pg, $urandom_range(49) == 0);
        end
    endtask

    task automatic pick_config();
        logic [7:0]  lim;
        logic [7:0]  upper;
        logic [15:0] seed;
        case ($urandom_range(0, 7))
            0: lim = 8'd1;
            1: lim = 8'($urandom_range(2, 8));
            2: lim = 8'($urandom_range(9, 40));
            3: lim = 8'($urandom_range(41, 127));
            4: lim = 8'd128;
            5: lim = 8'($urandom_range(129, 255));
            6: lim = 8'd0;
            default: lim = 8'($urandom_range(2, 24));
        endcase
        case ($urandom_range(0, 7))
            0: seed = 16'h0000;
            1: seed = 16'hFFFF;
            default: seed = 16'($urandom);
        endcase
        upper = 8'($urandom);
        if ($urandom_range(3) != 0) cfg_write(CFG_FRAME_LIMIT, {upper, lim});
        if ($urandom_range(3) != 0) cfg_write(CFG_RANDOM_SEED, seed);
    endtask

    initial begin : stimulus
        int phases;
        limit_shadow = LIMIT_RESET;
        seed_shadow  = SEED_RESET;
        clear_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: no eviction, hits, restart
        idle_pct = 25;
        queue_reference(0, 0);
        queue_reference(127, 0);
        queue_reference(0, 0);
        queue_reference(127, 0);
        queue_reference(64, 0);
        queue_reference(0, 1);
        queue_reference(0, 0);
        wait_idle();

        // zero limit acts as one, zero seed loads as one
        cfg_write(CFG_FRAME_LIMIT, 16'hA500);
        cfg_write(CFG_RANDOM_SEED, 16'h0000);
        cfg_write(CFG_SPARE, 16'h5A5A);
        queue_reference(1, 1);
        queue_reference(2, 0);
        queue_reference(2, 0);
        queue_reference(3, 0);
        wait_idle();

        // fill, then lower the limit below the allocated count
        cfg_write(CFG_FRAME_LIMIT, 16'h00FF);
        cfg_write(CFG_RANDOM_SEED, 16'hFFFF);
        for (int p = 10; p < 15; p++) queue_reference(p, p == 10);
        wait_idle();
        cfg_write(CFG_FRAME_LIMIT, 16'h0002);
        queue_reference(20, 0);
        queue_reference(21, 0);
        queue_reference(127, 0);
        queue_reference(0, 0);
        wait_idle();

        phases = 10;
        for (int ph = 0; ph < phases; ph++) begin
            pick_config();
            if (ph == phases - 1)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            queue_random_phase($urandom_range(100, 140));
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[random_page_replacement] OK");
        else
            $display("[random_page_replacement] ERROR");
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("[random_page_replacement] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rpr_pkg.sv
hdl/rpr_present_mem.sv
hdl/rpr_draw_unit.sv
hdl/random_page_replacement.sv
tb/sv/tb_top.sv
